FILE: hw/rtl/bounded_deque_count_erase_unit_defines.svh
// Assertion macros for the bounded deque unit.
// Uses clk_i and rst_ni of the module that includes it.
`ifndef BOUNDED_DEQUE_COUNT_ERASE_UNIT_DEFINES_SVH
`define BOUNDED_DEQUE_COUNT_ERASE_UNIT_DEFINES_SVH

// Clocked check, off while reset is asserted.
`define BDCE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bdce check failed");

// Same check with a caller-supplied message.
`define BDCE_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

FILE: hw/rtl/bdce_pkg.sv
// Shared types and constants for the bounded deque unit.
// No dependencies.
package bdce_pkg;

  localparam int unsigned DEPTH_DEF     = 16;
  localparam int unsigned WORD_BITS_DEF = 32;

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_COUNT      = 3'd4,
    REQ_ERASE      = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_UNDERFLOW = 2'd1,
    STAT_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_SHL  = 2'd1,
    CELL_SHR  = 2'd2
  } cell_op_e;

  typedef enum logic [1:0] {
    FSM_IDLE   = 2'd0,
    FSM_ROTATE = 2'd1,
    FSM_RESP   = 2'd2
  } fsm_e;

  // Control broadcast to every cell.
  typedef struct packed {
    cell_op_e op;
    logic     wr_en;
  } cell_ctrl_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] operand_word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] popped_word;
    logic [4:0]         match_count;
    logic [4:0]         occupancy;
    logic               is_empty;
    logic signed [31:0] front_word;
  } out_item_t;

endpackage

FILE: hw/rtl/bounded_deque_count_erase_unit.sv
// Bounded deque of signed words with count and order-keeping erase.
// Push/pop and requests on an empty store: IDLE, then RESP registers the result.
// Count/erase: ROTATE walks each stored word once past the head (cell 0), then RESP.
// One request at a time: in_stall_o is high outside IDLE, also while RESP waits on out_stall_i.
// Reset: async active low clears occupancy, FSM and output valid; cell words stay undefined.
module bounded_deque_count_erase_unit import bdce_pkg::*; #(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

`include "bounded_deque_count_erase_unit_defines.svh"

  // Fill count holds 0..DEPTH; cell index holds 0..DEPTH-1.
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // ---------------------------------------------------------------
  // Cell chain
  // ---------------------------------------------------------------
  cell_ctrl_t           cell_ctrl;
  logic [IDX_W-1:0]     wr_idx;
  logic [WORD_BITS-1:0] wr_data;
  logic [WORD_BITS-1:0] cell_word [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_BITS-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;              // push front writes cell 0 directly
    end else begin : g_mid_l
      assign left_w = cell_word[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;             // tail slot past the fill is don't care
    end else begin : g_mid_r
      assign right_w = cell_word[g+1];
    end

    bdce_cell #(
      .WORD_BITS (WORD_BITS),
      .IDX_W     (IDX_W),
      .IDX       (g)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (cell_ctrl),
      .wr_idx_i  (wr_idx),
      .wr_data_i (wr_data),
      .left_i    (left_w),
      .right_i   (right_w),
      .word_o    (cell_word[g])
    );
  end

  // ---------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------
  fsm_e             state_q, state_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] steps_q, steps_d;
  logic             out_valid_q, out_valid_d;

  // Per-request payload (no reset needed)
  logic [2:0]           req_q, req_d;
  logic [WORD_BITS-1:0] opnd_q, opnd_d;
  status_e              stat_q, stat_d;
  logic [31:0]          popped_q, popped_d;
  logic [CNT_W-1:0]     count_q, count_d;
  out_item_t            out_q, out_d;

  // Operand kept in its low WORD_BITS bits (zero-extended when wider).
  logic [WORD_BITS+31:0] opnd_ext;
  logic [WORD_BITS-1:0]  in_word;
  assign opnd_ext = {{WORD_BITS{1'b0}}, in_data_i.operand_word};
  assign in_word  = opnd_ext[WORD_BITS-1:0];

  logic             full, empty;
  logic [IDX_W-1:0] last_idx;
  assign full     = (fill_q == CNT_W'(DEPTH));
  assign empty    = (fill_q == '0);
  assign last_idx = IDX_W'(fill_q - CNT_W'(1));

  // Word leaving on a pop: head for pop front, tail for pop back.
  logic [WORD_BITS-1:0]  pop_sel;
  logic [WORD_BITS+31:0] pop_ext, head_ext;
  assign pop_sel  = (in_data_i.req_type == REQ_POP_FRONT) ? cell_word[0]
                                                          : cell_word[last_idx];
  assign pop_ext  = {{32{pop_sel[WORD_BITS-1]}}, pop_sel};
  assign head_ext = {{32{cell_word[0][WORD_BITS-1]}}, cell_word[0]};

  // Head compare used while rotating.
  logic head_match;
  assign head_match = (cell_word[0] == opnd_q);

  // Narrowing of counts to the 5-bit result fields.
  logic [CNT_W+4:0] fill_ext, count_ext;
  assign fill_ext  = {5'd0, fill_q};
  assign count_ext = {5'd0, count_q};

  logic in_xfer, out_free;
  assign in_stall_o = (state_q != FSM_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    steps_d     = steps_q;
    out_valid_d = out_valid_q;
    req_d       = req_q;
    opnd_d      = opnd_q;
    stat_d      = stat_q;
    popped_d    = popped_q;
    count_d     = count_q;
    out_d       = out_q;
    cell_ctrl   = '{op: CELL_HOLD, wr_en: 1'b0};
    wr_idx      = '0;
    wr_data     = in_word;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      FSM_IDLE: begin
        if (in_xfer) begin
          req_d    = in_data_i.req_type;
          opnd_d   = in_word;
          stat_d   = STAT_OK;
          popped_d = '0;
          count_d  = '0;
          steps_d  = fill_q;
          state_d  = FSM_RESP;
          case (in_data_i.req_type)
            REQ_PUSH_FRONT: begin
              if (full) begin
                stat_d = STAT_OVERFLOW;
              end else begin
                cell_ctrl = '{op: CELL_SHR, wr_en: 1'b1};
                wr_idx    = '0;
                fill_d    = fill_q + CNT_W'(1);
              end
            end
            REQ_PUSH_BACK: begin
              if (full) begin
                stat_d = STAT_OVERFLOW;
              end else begin
                cell_ctrl = '{op: CELL_HOLD, wr_en: 1'b1};
                wr_idx    = IDX_W'(fill_q);
                fill_d    = fill_q + CNT_W'(1);
              end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
              if (empty) begin
                stat_d = STAT_UNDERFLOW;
              end else begin
                popped_d = pop_ext[31:0];
                fill_d   = fill_q - CNT_W'(1);
                if (in_data_i.req_type == REQ_POP_FRONT) begin
                  cell_ctrl = '{op: CELL_SHL, wr_en: 1'b0};
                end
              end
            end
            REQ_COUNT: begin
              if (!empty) begin
                state_d = FSM_ROTATE;
              end
            end
            REQ_ERASE: begin
              if (empty) begin
                stat_d = STAT_UNDERFLOW;
              end else begin
                state_d = FSM_ROTATE;
              end
            end
            default: ;                 // unused codes: no operation
          endcase
        end
      end

      FSM_ROTATE: begin
        // Head leaves the chain; a kept word re-enters at the tail.
        cell_ctrl.op = CELL_SHL;
        wr_idx       = last_idx;
        wr_data      = cell_word[0];
        if ((req_q == REQ_ERASE) && head_match) begin
          fill_d = fill_q - CNT_W'(1);
        end else begin
          cell_ctrl.wr_en = 1'b1;
        end
        if (head_match) begin
          count_d = count_q + CNT_W'(1);
        end
        steps_d = steps_q - CNT_W'(1);
        if (steps_q == CNT_W'(1)) begin
          state_d = FSM_RESP;
        end
      end

      FSM_RESP: begin
        if (out_free) begin
          out_d.status      = stat_q;
          out_d.popped_word = popped_q;
          out_d.match_count = (req_q == REQ_COUNT) ? count_ext[4:0] : 5'd0;
          out_d.occupancy   = fill_ext[4:0];
          out_d.is_empty    = empty;
          out_d.front_word  = empty ? 32'd0 : head_ext[31:0];
          out_valid_d       = 1'b1;
          state_d           = FSM_IDLE;
        end
      end

      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      fill_q      <= '0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      steps_q     <= steps_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    opnd_q   <= opnd_d;
    stat_q   <= stat_d;
    popped_q <= popped_d;
    count_q  <= count_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  `BDCE_ASSERT(a_fill_bound, fill_q <= CNT_W'(DEPTH))
  `BDCE_ASSERT(a_xfer_busy, in_xfer |=> state_q != FSM_IDLE)
  `BDCE_ASSERT_MSG(a_rotate_no_grow,
    state_q == FSM_ROTATE |=> fill_q <= $past(fill_q),
    "fill grew during rotation")
  `BDCE_ASSERT_MSG(a_overflow_full,
    (state_q == FSM_RESP) && (stat_q == STAT_OVERFLOW) |-> full,
    "overflow reported with room left")

endmodule

FILE: hw/rtl/bdce_cell.sv
// One storage cell of the deque chain: holds a word, shifts to/from neighbors.
// Depends on bdce_pkg.
module bdce_cell import bdce_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF,
  parameter int unsigned IDX_W     = 4,
  parameter int unsigned IDX       = 0
) (
  input  logic                 clk_i,
  input  cell_ctrl_t           ctrl_i,
  input  logic [IDX_W-1:0]     wr_idx_i,
  input  logic [WORD_BITS-1:0] wr_data_i,
  input  logic [WORD_BITS-1:0] left_i,
  input  logic [WORD_BITS-1:0] right_i,
  output logic [WORD_BITS-1:0] word_o
);

  logic [WORD_BITS-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    case (ctrl_i.op)
      CELL_SHL: word_d = right_i;
      CELL_SHR: word_d = left_i;
      default:  word_d = word_q;
    endcase
    // direct write wins over the shift
    if (ctrl_i.wr_en && (wr_idx_i == IDX_W'(IDX))) begin
      word_d = wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule
